/* rtl/fmct_pkg.sv */
// ============================================================================
// fmct_pkg: shared types and constants for the fec mask coverage table
// Operation codes, controller states and the transaction token that walks
// the row of slot cells.
// ============================================================================
`default_nettype none

package fmct_pkg;

  localparam int DEF_ENTRIES = 16;

  localparam int SEQ_W    = 32;
  localparam int MASK_W   = 16;
  localparam int HANDLE_W = 16;

  // slot index carried by a token, wide enough for the largest table
  localparam int SLOT_IDX_W = 8;

  // coverage window: offset 0, mask bits 1..16, continuation bits 17..32
  localparam int MASK_SPAN  = 16;
  localparam int COVER_SPAN = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CHECK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_LAUNCH,
    ST_SCAN
  } ctrl_state_t;

  typedef struct packed {
    logic                  valid;
    op_t                   op;
    logic [SEQ_W-1:0]      seq;
    logic [MASK_W-1:0]     mask;
    logic [MASK_W-1:0]     ext_mask;
    logic [HANDLE_W-1:0]   handle;
    logic [SLOT_IDX_W-1:0] idx;
    logic                  found;
    logic                  evicted;
    logic [HANDLE_W-1:0]   res_handle;
    logic [SEQ_W-1:0]      res_base;
  } token_t;

endpackage

`default_nettype wire

/* rtl/fec_mask_coverage_table_unit.sv */
// ============================================================================
// fec_mask_coverage_table_unit: slotted table of fec packet records
// Insert, get, remove and check against per-record protection masks.
// ============================================================================
// sequence: get, remove and check launch a token once accepted and the result
//   register is free; insert first runs the slot-index remainder (quotient,
//   then remainder), sees it done, then launches the same way; the token walks
//   the ENTRIES slot cells one cell a cycle, then loads the result register
// throughput: one transaction at a time; a result still waiting on
//   out_stall holds the next launch, not its accept
// reset: synchronous, clears every slot valid bit and all handshake state
`default_nettype none

module fec_mask_coverage_table_unit
  import fmct_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          op,
  input  wire logic [SEQ_W-1:0]    seq,
  input  wire logic [MASK_W-1:0]   prot_mask,
  input  wire logic [MASK_W-1:0]   prot_mask_cont,
  input  wire logic [HANDLE_W-1:0] rec_handle,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     status,
  output logic [HANDLE_W-1:0]      out_handle,
  output logic [SEQ_W-1:0]         out_base,
  output logic                     evicted
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // transaction captured at accept
  op_t                 req_op;
  logic [SEQ_W-1:0]    req_seq;
  logic [MASK_W-1:0]   req_mask;
  logic [MASK_W-1:0]   req_ext_mask;
  logic [HANDLE_W-1:0] req_handle;

  logic                  in_take;
  logic                  out_take;
  logic                  out_free;
  logic                  rem_start;
  logic                  rem_busy;
  logic [SLOT_IDX_W-1:0] rem;
  logic                  launch;

  // token path: entry at index 0, exit at index ENTRIES
  token_t tok [ENTRIES+1];
  token_t tok_first;
  token_t tok_last;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  // result register empty by the time the token leaves the row
  assign out_free = !out_valid || !out_stall;
  assign tok[0]   = tok_first;
  assign tok_last = tok[ENTRIES];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = (op_t'(op) == OP_INSERT) ? ST_DIVIDE : ST_LAUNCH;
        end
      end
      ST_DIVIDE: begin
        if (!rem_busy) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        if (out_free) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok_last.valid) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_stall  = 1'b1;
    rem_start = 1'b0;
    launch    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        rem_start = in_valid && (op_t'(op) == OP_INSERT);
      end
      ST_LAUNCH: begin
        launch = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_op       <= op_t'(op);
      req_seq      <= seq;
      req_mask     <= prot_mask;
      req_ext_mask <= prot_mask_cont;
      req_handle   <= rec_handle;
    end
  end

  // slot index = base mod ENTRIES, only needed for insert
  fmct_rem_unit #(
    .ENTRIES (ENTRIES)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (seq),
    .busy     (rem_busy),
    .rem      (rem)
  );

  // fresh token: nothing found, result fields zero
  always_comb begin
    tok_first.valid      = launch;
    tok_first.op         = req_op;
    tok_first.seq        = req_seq;
    tok_first.mask       = req_mask;
    tok_first.ext_mask   = req_ext_mask;
    tok_first.handle     = req_handle;
    tok_first.idx        = rem;
    tok_first.found      = 1'b0;
    tok_first.evicted    = 1'b0;
    tok_first.res_handle = '0;
    tok_first.res_base   = '0;
  end

  // row of slot cells, lowest index first so the first cover wins
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    fmct_cell #(
      .ID (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tok_last.valid) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_last.valid) begin
      status     <= (tok_last.op != OP_INSERT) && !tok_last.found;
      out_handle <= tok_last.res_handle;
      out_base   <= tok_last.res_base;
      evicted    <= tok_last.evicted;
    end
  end

`ifndef SYNTHESIS
  // a token leaves the row only while the controller waits for it
  a_exit_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok_last.valid |-> state == ST_SCAN)
    else $error("token left the row outside the scan state");

  // the result register is always free while a token walks the row
  a_out_free_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> !out_valid)
    else $error("result register occupied during scan");

  // remainder unit runs only for an insert being indexed
  a_rem_in_divide: assert property (@(posedge clk) disable iff (rst)
    rem_busy |-> state == ST_DIVIDE)
    else $error("remainder unit busy outside the divide state");

  // an accepted transaction always leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state != ST_IDLE)
    else $error("controller stayed idle after accept");
`endif

endmodule

`default_nettype wire

/* rtl/fmct_rem_unit.sv */
// ============================================================================
// fmct_rem_unit: slot index of a base sequence number
// Remainder of a 32-bit value by ENTRIES through a reciprocal multiply,
// quotient registered first, remainder registered from it after.
// ============================================================================
`default_nettype none

module fmct_rem_unit
  import fmct_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [SEQ_W-1:0]      dividend,
  output logic                       busy,
  output logic [SLOT_IDX_W-1:0]      rem
);

  // quotient = x * ceil(2^(32+SH) / ENTRIES) >> (32+SH), exact for 32-bit x
  localparam int SH = $clog2(ENTRIES);

  function automatic logic [SEQ_W:0] recip_f(input int divisor, input int shift);
    logic [63:0] num;
    num = (64'd1 << (SEQ_W + shift)) + 64'(divisor) - 64'd1;
    return (SEQ_W + 1)'(num / 64'(divisor));
  endfunction

  localparam logic [SEQ_W:0]   RECIP = recip_f(ENTRIES, SH);
  localparam logic [SEQ_W-1:0] DIV_K = SEQ_W'(ENTRIES);

  logic                  stage;
  logic [SEQ_W-1:0]      x;
  logic [SEQ_W-1:0]      quot;
  logic [2*SEQ_W:0]      prod;
  logic [SEQ_W-1:0]      back;
  logic [SLOT_IDX_W-1:0] r;

  always_comb begin
    prod = (2*SEQ_W + 1)'(x) * (2*SEQ_W + 1)'(RECIP);
    // remainder is below ENTRIES, so wrapping at 32 bits is harmless
    back = x - quot * DIV_K;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      stage <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      stage <= 1'b0;
    end else if (busy && !stage) begin
      stage <= 1'b1;
    end else if (busy) begin
      busy  <= 1'b0;
      stage <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= dividend;
    end
    if (busy && !stage) begin
      quot <= SEQ_W'(prod >> (SEQ_W + SH));
    end
    if (busy && stage) begin
      r <= SLOT_IDX_W'(back);
    end
  end

  assign rem = r;

endmodule

`default_nettype wire

/* rtl/fmct_cell.sv */
// ============================================================================
// fmct_cell: one slot of the coverage table
// Holds one record and passes the transaction token on to the next slot.
// ============================================================================
`default_nettype none

module fmct_cell
  import fmct_pkg::*;
#(
  parameter int ID = 0
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire token_t tok_in,
  output token_t      tok_out
);

  localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(ID);

  logic                slot_valid;
  logic [SEQ_W-1:0]    slot_base;
  logic [MASK_W-1:0]   slot_mask;
  logic [MASK_W-1:0]   slot_ext_mask;
  logic [HANDLE_W-1:0] slot_handle;

  logic [SEQ_W-1:0]     diff;
  logic [COVER_SPAN:0]  cover_vec;
  logic                 hit;
  logic                 do_write;
  logic                 do_clear;
  token_t               tok_next;

  // offset from base selects a bit of {cont, mask, always-covered base}
  always_comb begin
    diff      = tok_in.seq - slot_base;
    cover_vec = {slot_ext_mask, slot_mask, 1'b1};
    hit       = (diff <= SEQ_W'(COVER_SPAN)) && cover_vec[diff[5:0]];
  end

  always_comb begin
    tok_next = tok_in;
    do_write = 1'b0;
    do_clear = 1'b0;
    if (tok_in.valid) begin
      if (tok_in.op == OP_INSERT) begin
        if (tok_in.idx == MY_IDX) begin
          do_write = 1'b1;
          if (slot_valid) begin
            tok_next.evicted    = 1'b1;
            tok_next.res_handle = slot_handle;
            tok_next.res_base   = slot_base;
          end
        end
      end else if (!tok_in.found && slot_valid && hit) begin
        tok_next.found = 1'b1;
        if (tok_in.op != OP_CHECK) begin
          tok_next.res_handle = slot_handle;
          tok_next.res_base   = slot_base;
        end
        do_clear = (tok_in.op == OP_REMOVE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (do_write) begin
      slot_valid <= 1'b1;
    end else if (do_clear) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      slot_base     <= tok_in.seq;
      slot_mask     <= tok_in.mask;
      slot_ext_mask <= tok_in.ext_mask;
      slot_handle   <= tok_in.handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire
